### design/fir_decimator_unit_macros.svh
`ifndef FIR_DECIMATOR_UNIT_MACROS_SVH
`define FIR_DECIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset
`define FD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fir_decimator_unit: same-cycle check failed");

// Next-cycle implication
`define FD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fir_decimator_unit: next-cycle check failed");

`endif

### design/fir_dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fir_dec_pkg;

	localparam int MAX_TAPS  = 128;
	localparam int MAX_DECIM = 64;

	localparam int DW      = 16;                       // Q1.15 sample / coefficient
	localparam int IDX_W   = 7;                        // coef_index field
	localparam int DREG_W  = 7;                        // decim_factor register
	localparam int TREG_W  = 8;                        // tap_count register
	localparam int CFG_AW  = 1;
	localparam int CFG_DW  = 8;
	localparam int TAP_AW  = $clog2(MAX_TAPS);         // history/coefficient address
	localparam int TAP_CW  = $clog2(MAX_TAPS + 1);     // tap count, fill count
	localparam int FAC_W   = $clog2(MAX_DECIM + 1);    // factor and phase
	localparam int PROD_W  = 2 * DW;
	localparam int ACC_W   = 40;
	localparam int FRAC    = 15;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [CFG_AW-1:0] REG_DECIM = 1'd0;
	localparam logic [CFG_AW-1:0] REG_TAPS  = 1'd1;

	// operation kinds decided by the front end
	localparam logic [1:0] OP_DROP        = 2'd0;
	localparam logic [1:0] OP_COEF        = 2'd1;
	localparam logic [1:0] OP_SAMPLE      = 2'd2;
	localparam logic [1:0] OP_SAMPLE_EMIT = 2'd3;

	typedef struct packed {
		logic [1:0]             kind;
		logic signed [DW-1:0]   value;
		logic [IDX_W-1:0]       coef_index;
	} fd_op_t;

	typedef struct packed {
		logic busy;   // MAC sequence in progress
		logic pop;    // op taken from the queue this cycle
	} fd_stat_t;

endpackage

`default_nettype wire

### design/fir_decimator_unit.sv
// Coefficient write or non-emitting sample: no result; the back end pops it while idle.
// Emitting sample: the shared multiply-accumulate walks one tap per cycle, then the read,
// product and accumulate registers drain before filtered is registered; the back end
// takes no new op until then. The front takes one item a cycle, while the 2-entry queue
// is not full. Reset: decim_factor = 1, tap_count = 1, phase 0, delay line reads zero
// (fill count), coefficient memory undefined until written; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "fir_decimator_unit_macros.svh"

module fir_decimator_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [fir_dec_pkg::CFG_AW-1:0]        cfg_addr,
	input  wire logic [fir_dec_pkg::CFG_DW-1:0]        cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  cmd,
	input  wire logic signed [fir_dec_pkg::DW-1:0]     value,
	input  wire logic [fir_dec_pkg::IDX_W-1:0]         coef_index,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [fir_dec_pkg::DW-1:0]          filtered
);

	logic [fir_dec_pkg::DREG_W-1:0] decim_q;
	logic [fir_dec_pkg::TREG_W-1:0] taps_q;
	logic [fir_dec_pkg::FAC_W-1:0]  eff_factor;
	logic [fir_dec_pkg::TAP_CW-1:0] eff_taps;
	logic                           push;
	fir_dec_pkg::fd_op_t            push_op;
	logic                           q_full;
	logic                           head_valid;
	fir_dec_pkg::fd_op_t            head_op;
	fir_dec_pkg::fd_stat_t          stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= fir_dec_pkg::DREG_W'(1);
			taps_q  <= fir_dec_pkg::TREG_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				fir_dec_pkg::REG_DECIM: decim_q <= cfg_data[fir_dec_pkg::DREG_W-1:0];
				fir_dec_pkg::REG_TAPS:  taps_q  <= cfg_data[fir_dec_pkg::TREG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp the registers to the supported ranges, zero means one
	always_comb begin
		if (decim_q == '0) begin
			eff_factor = fir_dec_pkg::FAC_W'(1);
		end else if (32'(decim_q) > fir_dec_pkg::MAX_DECIM) begin
			eff_factor = fir_dec_pkg::FAC_W'(fir_dec_pkg::MAX_DECIM);
		end else begin
			eff_factor = fir_dec_pkg::FAC_W'(decim_q);
		end
		if (taps_q == '0) begin
			eff_taps = fir_dec_pkg::TAP_CW'(1);
		end else if (32'(taps_q) > fir_dec_pkg::MAX_TAPS) begin
			eff_taps = fir_dec_pkg::TAP_CW'(fir_dec_pkg::MAX_TAPS);
		end else begin
			eff_taps = fir_dec_pkg::TAP_CW'(taps_q);
		end
	end

	fir_dec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.value      (value),
		.coef_index (coef_index),
		.eff_factor (eff_factor),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op)
	);

	fir_dec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (stat.pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	fir_dec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (head_valid),
		.op         (head_op),
		.eff_taps   (eff_taps),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered   (filtered)
	);

	`FD_ASSERT_IMP(a_no_pop_while_busy, stat.busy, !stat.pop)
	`FD_ASSERT_NXT(a_coef_no_mac, stat.pop && (head_op.kind == fir_dec_pkg::OP_COEF), !stat.busy)
	`FD_ASSERT_NXT(a_emit_starts_mac, stat.pop && (head_op.kind == fir_dec_pkg::OP_SAMPLE_EMIT), stat.busy)
	`FD_ASSERT_IMP(a_result_after_mac, $rose(out_valid), $past(stat.busy))

endmodule

`default_nettype wire

### design/fir_dec_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fir_dec_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              cmd,
	input  wire logic signed [fir_dec_pkg::DW-1:0] value,
	input  wire logic [fir_dec_pkg::IDX_W-1:0]     coef_index,
	input  wire logic [fir_dec_pkg::FAC_W-1:0]     eff_factor,
	input  wire logic                              q_full,
	output logic                                   push,
	output fir_dec_pkg::fd_op_t                    push_op
);

	logic [fir_dec_pkg::FAC_W-1:0] phase_q;
	logic [fir_dec_pkg::FAC_W:0]   phase_inc;
	logic                          xfer;
	logic                          is_sample;

	assign in_ready  = !q_full;
	assign xfer      = in_valid && in_ready;
	assign is_sample = (cmd == 1'b0);
	assign phase_inc = {1'b0, phase_q} + {{fir_dec_pkg::FAC_W{1'b0}}, 1'b1};

	always_comb begin
		push_op.value      = value;
		push_op.coef_index = coef_index;
		if (is_sample) begin
			push_op.kind = (phase_q == '0) ? fir_dec_pkg::OP_SAMPLE_EMIT
			                               : fir_dec_pkg::OP_SAMPLE;
		end else if (32'(coef_index) < fir_dec_pkg::MAX_TAPS) begin
			push_op.kind = fir_dec_pkg::OP_COEF;
		end else begin
			push_op.kind = fir_dec_pkg::OP_DROP;
		end
	end

	assign push = xfer;

	// advance the decimation phase on every sample, wrap at the factor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (xfer && is_sample) begin
			if (phase_inc >= {1'b0, eff_factor}) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_inc[fir_dec_pkg::FAC_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

### design/fir_dec_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fir_dec_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire fir_dec_pkg::fd_op_t  push_op,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      head_valid,
	output fir_dec_pkg::fd_op_t       head_op
);

	fir_dec_pkg::fd_op_t               slot_q [fir_dec_pkg::QDEPTH];
	logic [fir_dec_pkg::QPTR_W-1:0]    wr_q;
	logic [fir_dec_pkg::QPTR_W-1:0]    rd_q;
	logic [fir_dec_pkg::QCNT_W-1:0]    cnt_q;
	logic                              do_push;
	logic                              do_pop;

	localparam logic [fir_dec_pkg::QPTR_W-1:0] PTR_LAST =
		fir_dec_pkg::QPTR_W'(fir_dec_pkg::QDEPTH - 1);
	localparam logic [fir_dec_pkg::QCNT_W-1:0] CNT_FULL =
		fir_dec_pkg::QCNT_W'(fir_dec_pkg::QDEPTH);

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_op    = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

### design/fir_dec_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fir_dec_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               op_valid,
	input  wire fir_dec_pkg::fd_op_t                op,
	input  wire logic [fir_dec_pkg::TAP_CW-1:0]     eff_taps,
	output fir_dec_pkg::fd_stat_t                   stat,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [fir_dec_pkg::DW-1:0]       filtered
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam int AW = fir_dec_pkg::TAP_AW;
	localparam int CW = fir_dec_pkg::TAP_CW;
	localparam int DW = fir_dec_pkg::DW;
	localparam int PW = fir_dec_pkg::PROD_W;
	localparam int AC = fir_dec_pkg::ACC_W;
	localparam int FR = fir_dec_pkg::FRAC;

	localparam logic signed [AC-1:0] ACC_MAX = {1'b0, {(AC-1){1'b1}}};
	localparam logic signed [AC-1:0] ACC_MIN = {1'b1, {(AC-1){1'b0}}};
	localparam logic signed [AC:0]   RND_BIAS = (AC+1)'(1) <<< (FR - 1);
	localparam logic signed [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [CW-1:0]        FILL_FULL = CW'(fir_dec_pkg::MAX_TAPS);

	logic signed [DW-1:0] coef_mem [fir_dec_pkg::MAX_TAPS];
	logic signed [DW-1:0] hist_mem [fir_dec_pkg::MAX_TAPS];

	logic [1:0]           state_q;
	logic [AW-1:0]        j_q;
	logic [AW-1:0]        head_q;
	logic [AW-1:0]        head_nxt;
	logic [CW-1:0]        fill_q;
	logic [CW-1:0]        taps_m1;
	logic                 vld_s1;
	logic                 vld_s2;
	logic                 out_valid_q;
	logic signed [DW-1:0] coef_s1;
	logic signed [DW-1:0] hist_s1;
	logic                 hok_s1;
	logic signed [PW-1:0] prod_s2;
	logic signed [AC-1:0] acc_q;
	logic signed [AC:0]   acc_sum;
	logic signed [AC:0]   rnd;
	logic signed [DW-1:0] rnd_sat;
	logic signed [DW-1:0] filtered_q;
	logic                 pop;
	logic                 is_sample;
	logic                 start;
	logic                 last_tap;
	logic                 finish;

	assign pop       = (state_q == ST_IDLE) && op_valid;
	assign is_sample = (op.kind == fir_dec_pkg::OP_SAMPLE) ||
	                   (op.kind == fir_dec_pkg::OP_SAMPLE_EMIT);
	assign start     = pop && (op.kind == fir_dec_pkg::OP_SAMPLE_EMIT);
	assign head_nxt  = head_q + 1'b1;
	assign taps_m1   = eff_taps - CW'(1);
	assign last_tap  = ({1'b0, j_q} == taps_m1);
	assign finish    = (state_q == ST_DRAIN) && !vld_s1 && !vld_s2 &&
	                   (!out_valid_q || out_ready);

	assign stat      = '{busy: (state_q != ST_IDLE), pop: pop};
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	// saturating 40-bit accumulate
	always_comb begin
		acc_sum = {acc_q[AC-1], acc_q} + {{(AC+1-PW){prod_s2[PW-1]}}, prod_s2};
	end

	// round half up, then clamp to Q1.15
	always_comb begin
		rnd = {acc_q[AC-1], acc_q} + RND_BIAS;
		if ((&rnd[AC:FR+DW-1]) || !(|rnd[AC:FR+DW-1])) begin
			rnd_sat = rnd[FR+DW-1:FR];
		end else begin
			rnd_sat = rnd[AC] ? OUT_MIN : OUT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			j_q         <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
			vld_s2 <= vld_s1;
			if (out_valid_q && out_ready && !finish) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && is_sample) begin
						head_q <= head_nxt;
						if (fill_q != FILL_FULL) begin
							fill_q <= fill_q + 1'b1;
						end
					end
					if (start) begin
						j_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					j_q <= j_q + 1'b1;
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// coefficient memory: write from the queue, read by tap index
	always_ff @(posedge clk) begin
		if (pop && (op.kind == fir_dec_pkg::OP_COEF)) begin
			coef_mem[op.coef_index[AW-1:0]] <= op.value;
		end
		coef_s1 <= coef_mem[j_q];
	end

	// sample ring: newest at head_q, tap j sits at head_q - j
	always_ff @(posedge clk) begin
		if (pop && is_sample) begin
			hist_mem[head_nxt] <= op.value;
		end
		hist_s1 <= hist_mem[head_q - j_q];
	end

	always_ff @(posedge clk) begin
		// entries past the fill count stand for the zeroed delay line
		hok_s1  <= ({1'b0, j_q} < fill_q);
		prod_s2 <= hok_s1 ? PW'(coef_s1 * hist_s1) : '0;
		if (start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			if (acc_sum[AC] != acc_sum[AC-1]) begin
				acc_q <= acc_sum[AC] ? ACC_MIN : ACC_MAX;
			end else begin
				acc_q <= acc_sum[AC-1:0];
			end
		end
		if (finish) begin
			filtered_q <= rnd_sat;
		end
	end

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int                            MAX_TAPS  = fir_dec_pkg::MAX_TAPS;
	localparam int                            MAX_DECIM = fir_dec_pkg::MAX_DECIM;
	localparam int                            DW        = fir_dec_pkg::DW;
	localparam int                            IDX_W     = fir_dec_pkg::IDX_W;
	localparam int                            CFG_AW    = fir_dec_pkg::CFG_AW;
	localparam int                            CFG_DW    = fir_dec_pkg::CFG_DW;
	localparam int                            DREG_W    = fir_dec_pkg::DREG_W;
	localparam int                            TREG_W    = fir_dec_pkg::TREG_W;
	localparam int                            ACC_W     = fir_dec_pkg::ACC_W;
	localparam int                            FRAC      = fir_dec_pkg::FRAC;
	localparam logic [fir_dec_pkg::CFG_AW-1:0] REG_DECIM = fir_dec_pkg::REG_DECIM;
	localparam logic [fir_dec_pkg::CFG_AW-1:0] REG_TAPS  = fir_dec_pkg::REG_TAPS;

	localparam logic    CMD_SAMPLE   = 1'b0;
	localparam logic    CMD_COEF     = 1'b1;
	localparam int      MAX_GAP      = 18;
	localparam int      SETTLE_CYC   = MAX_TAPS + 24;
	localparam int      SQUEEZE_CYC  = 800;
	localparam int      RANDOM_ITEMS = 1300;
	localparam int      SQUEEZE_PH   = 4;
	localparam longint  ACC_HI       = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint  ACC_LO       = -ACC_HI - 1;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic                 cmd;
		logic signed [DW-1:0] value;
		logic [IDX_W-1:0]     index;
		bit                   has_y;
		logic signed [DW-1:0] y;
		logic [CFG_AW-1:0]    addr;
		logic [CFG_DW-1:0]    data;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_AW-1:0]    cfg_addr;
	logic [CFG_DW-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cmd;
	logic signed [DW-1:0] value;
	logic [IDX_W-1:0]     coef_index;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [DW-1:0] filtered;

	// filter state as the bench tracks it
	logic signed [DW-1:0] coef_mem [MAX_TAPS];
	logic signed [DW-1:0] delay_line [MAX_TAPS];
	int unsigned          phase_cnt;
	logic [DREG_W-1:0]    decim_reg;
	logic [TREG_W-1:0]    taps_reg;

	logic signed [DW-1:0] pending_filtered [$];
	int                   errors;
	bit                   no_idle;
	bit                   squeeze_req;
	bit                   hold_out;

	fir_decimator_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.value      (value),
		.coef_index (coef_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered   (filtered)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void predict_filtered(input logic c, input logic signed [DW-1:0] v,
			input logic [IDX_W-1:0] ix, output bit emits, output logic signed [DW-1:0] y);
		longint      acc;
		longint      q;
		int unsigned taps;
		int unsigned fac;
		int          j;
		emits = 1'b0;
		y = '0;
		if (c == CMD_COEF) begin
			coef_mem[ix] = v;
			return;
		end
		for (j = MAX_TAPS - 1; j > 0; j--)
			delay_line[j] = delay_line[j-1];
		delay_line[0] = v;
		if (phase_cnt == 0) begin
			taps = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
			acc = 0;
			for (j = 0; j < taps; j++) begin
				acc += longint'(coef_mem[j]) * longint'(delay_line[j]);
				if (acc > ACC_HI)
					acc = ACC_HI;
				else if (acc < ACC_LO)
					acc = ACC_LO;
			end
			// round half up, then clamp to Q1.15
			q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
			if (q > 32767)
				y = 16'sh7FFF;
			else if (q < -32768)
				y = 16'sh8000;
			else
				y = q[DW-1:0];
			emits = 1'b1;
		end
		fac = (decim_reg == 0) ? 1 : (decim_reg > MAX_DECIM) ? MAX_DECIM : decim_reg;
		phase_cnt = (phase_cnt + 1 >= fac) ? 0 : phase_cnt + 1;
	endfunction

	function automatic logic signed [DW-1:0] rand_word();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 16'sh7FFF;
		if (r == 1)
			return 16'sh8000;
		if (r == 2)
			return DW'(int'($urandom_range(0, 511)) - 256);
		return DW'($urandom);
	endfunction

	function automatic plan_row_t mk_item(input logic c, input logic signed [DW-1:0] v,
			input logic [IDX_W-1:0] ix);
		plan_row_t row;
		row.kind  = ROW_ITEM;
		row.cmd   = c;
		row.value = v;
		row.index = ix;
		row.has_y = 1'b0;
		row.y     = '0;
		row.addr  = '0;
		row.data  = '0;
		return row;
	endfunction

	function automatic plan_row_t mk_checked(input logic signed [DW-1:0] v,
			input logic signed [DW-1:0] y);
		plan_row_t row;
		row = mk_item(CMD_SAMPLE, v, '0);
		row.has_y = 1'b1;
		row.y     = y;
		return row;
	endfunction

	function automatic plan_row_t mk_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
		plan_row_t row;
		row = mk_item(CMD_SAMPLE, '0, '0);
		row.kind = ROW_REG;
		row.addr = a;
		row.data = d;
		return row;
	endfunction

	task automatic send_item(input logic c, input logic signed [DW-1:0] v,
			input logic [IDX_W-1:0] ix, input bit has_y, input logic signed [DW-1:0] y_typed);
		int                   gap;
		bit                   emits;
		logic signed [DW-1:0] y;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		value      <= v;
		coef_index <= ix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_filtered(c, v, ix, emits, y);
		if (emits)
			pending_filtered.push_back(has_y ? y_typed : y);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
		cfg_we   <= 1'b1;
		cfg_addr <= a;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (a == REG_DECIM)
			decim_reg = d[DREG_W-1:0];
		else
			taps_reg = d[TREG_W-1:0];
	endtask

	// drop valid, let every result drain, then cover work that yields none
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_filtered.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	initial begin : stimulus
		plan_row_t         plan [$];
		int                n_items;
		int                sent;
		int                ph;
		int                k;
		int                r;
		logic [DREG_W-1:0] dsel;
		logic [TREG_W-1:0] tsel;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_addr   <= '0;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		cmd        <= CMD_SAMPLE;
		value      <= '0;
		coef_index <= '0;
		no_idle     = 1'b0;
		squeeze_req = 1'b0;
		errors      = 0;
		for (k = 0; k < MAX_TAPS; k++) begin
			coef_mem[k]   = '0;
			delay_line[k] = '0;
		end
		phase_cnt = 0;
		decim_reg = DREG_W'(1);
		taps_reg  = TREG_W'(1);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(mk_item(CMD_COEF, 16'sd1, 7'd0));
		plan.push_back(mk_checked(16'sd16384, 16'sd1));
		plan.push_back(mk_checked(-16'sd16384, 16'sd0));
		plan.push_back(mk_checked(-16'sd16385, -16'sd1));
		plan.push_back(mk_checked(16'sd0, 16'sd0));
		plan.push_back(mk_item(CMD_COEF, 16'sh8000, 7'd0));
		plan.push_back(mk_checked(16'sh8000, 16'sh7FFF));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sh7FFF, 7'd127));
		plan.push_back(mk_item(CMD_COEF, 16'sh8000, 7'd1));
		plan.push_back(mk_item(CMD_COEF, 16'sh7FFF, 7'd2));
		plan.push_back(mk_item(CMD_COEF, 16'sh7FFF, 7'd127));
		plan.push_back(mk_reg(REG_TAPS, 8'd3));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sh8000, 7'd0));
		plan.push_back(mk_reg(REG_TAPS, 8'd0));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sd12345, 7'd0));
		plan.push_back(mk_reg(REG_DECIM, 8'd2));
		plan.push_back(mk_item(CMD_SAMPLE, -16'sd1, 7'd0));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sd1, 7'd0));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sh7FFF, 7'd0));
		// phase is now past the new factor and must wrap on the next sample
		plan.push_back(mk_reg(REG_DECIM, 8'd0));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sd100, 7'd0));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sd200, 7'd0));
		plan.push_back(mk_reg(REG_DECIM, 8'd127));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sh8000, 7'd0));
		plan.push_back(mk_item(CMD_SAMPLE, 16'sd5, 7'd0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(plan[i].addr, plan[i].data);
			end else begin
				send_item(plan[i].cmd, plan[i].value, plan[i].index, plan[i].has_y, plan[i].y);
			end
		end

		// fill the whole coefficient table before any tap count may reach it
		for (k = 0; k < MAX_TAPS; k++)
			send_item(CMD_COEF, rand_word(), IDX_W'(k), 1'b0, '0);

		sent = MAX_TAPS;
		for (ph = 0; sent < RANDOM_ITEMS; ph++) begin
			wait_idle();
			r = $urandom_range(0, 9);
			if (ph == SQUEEZE_PH || r <= 5)
				dsel = DREG_W'((ph == SQUEEZE_PH) ? 1 : $urandom_range(1, 8));
			else if (r == 6)
				dsel = DREG_W'(MAX_DECIM);
			else if (r == 7)
				dsel = '0;
			else if (r == 8)
				dsel = DREG_W'($urandom_range(MAX_DECIM + 1, 127));
			else
				dsel = DREG_W'($urandom_range(9, MAX_DECIM - 1));
			r = $urandom_range(0, 9);
			if (r <= 5)
				tsel = TREG_W'($urandom_range(1, 12));
			else if (r == 6)
				tsel = TREG_W'(MAX_TAPS);
			else if (r == 7)
				tsel = '0;
			else if (r == 8)
				tsel = TREG_W'($urandom_range(MAX_TAPS + 1, 255));
			else
				tsel = TREG_W'($urandom_range(13, MAX_TAPS - 1));
			// the top data bit lies outside the factor register
			write_reg(REG_DECIM, {1'($urandom_range(0, 1)), dsel});
			write_reg(REG_TAPS, tsel);
			no_idle = (ph == SQUEEZE_PH) || ($urandom_range(0, 3) == 0);
			if (ph == SQUEEZE_PH)
				squeeze_req = 1'b1;
			n_items = $urandom_range(20, 90);
			repeat (n_items) begin
				if ($urandom_range(0, 9) == 0)
					send_item(CMD_COEF, rand_word(), IDX_W'($urandom_range(0, 127)), 1'b0, '0);
				else
					send_item(CMD_SAMPLE, rand_word(), IDX_W'($urandom_range(0, 127)), 1'b0, '0);
			end
			sent += n_items;
		end

		wait_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : result_side
		int                   stall;
		logic signed [DW-1:0] want;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0 || hold_out) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_out) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_filtered.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer: filtered %0d", filtered);
			end else begin
				want = pending_filtered.pop_front();
				if (filtered !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch on filtered: expected %0d, got %0d", want, filtered);
				end
			end
		end
	end

	// hold the output off long enough that the input side backs up
	initial begin : squeeze
		hold_out <= 1'b0;
		wait (squeeze_req);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (SQUEEZE_CYC) @(posedge clk);
		hold_out <= 1'b0;
	end

	initial begin : watchdog
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
